### design/deq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and ring arithmetic for the double-ended queue.
// No dependencies; every design file but deq_ram imports this package.
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = 32;

    typedef logic [AW-1:0] t_addr;
    typedef logic [CW-1:0] t_count;
    typedef logic [2:0]    t_cmd;
    typedef logic [1:0]    t_status;

    localparam t_cmd CMD_PUSH_FRONT = 3'd0;
    localparam t_cmd CMD_PUSH_BACK  = 3'd1;
    localparam t_cmd CMD_POP_FRONT  = 3'd2;
    localparam t_cmd CMD_POP_BACK   = 3'd3;
    localparam t_cmd CMD_LIST       = 3'd4;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_LIST = 3'b100
    } t_state;

    // Ring position base + off, wrapped at DEPTH. Both operands stay below DEPTH.
    function automatic t_addr ring_add(input t_addr base, input t_addr off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

endpackage

### design/deq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
module deq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### design/double_ended_queue_core.sv
`timescale 1ns / 1ps
// Top level of the bounded double-ended queue: command sequencer and ring pointers.
// Depends on deq_pkg and deq_ram.
//
//  Channel  | Handshake                        | Payload
//  ---------+----------------------------------+------------------------------
//  request  | start in, busy out (start&!busy) | i_cmd, i_value
//  result   | o_strobe out, one cycle each     | o_item, o_status, o_last
//
// A push writes the word, and its result shows in the next cycle.
// A pop passes through S_POP while the entry memory returns its registered read data.
// A list makes one read per entry through the single read port, with results back to back.
// Rejected pushes and pops and an empty list answer in the next cycle.
// Reset is synchronous and active low; it empties the queue (memory contents are kept).
// Busy stays high while reset is held, so no request is taken during reset.
// The receiver cannot stall; busy is the only back-pressure toward the requester.
module double_ended_queue_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  deq_pkg::t_cmd           i_cmd,
    input  logic signed [31:0]      i_value,
    output logic                    o_strobe,
    output logic signed [31:0]      o_item,
    output deq_pkg::t_status        o_status,
    output logic                    o_last
);
    import deq_pkg::*;

    t_state  r_state, n_state;
    t_addr   r_front, n_front;
    t_count  r_occ,   n_occ;
    t_count  r_idx,   n_idx;

    logic               r_strobe, n_strobe;
    logic signed [31:0] r_item,   n_item;
    t_status            r_status, n_status;
    logic               r_last,   n_last;

    logic            ram_we;
    t_addr           ram_waddr;
    t_addr           ram_raddr;
    logic [DW-1:0]   ram_rdata;
    logic            accept;
    logic            is_full;
    logic            is_empty;
    logic            list_done;

    deq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy      = (r_state != S_IDLE) || !i_rst_n;
    assign accept    = start && !busy;
    assign is_full   = (r_occ == CW'(DEPTH));
    assign is_empty  = (r_occ == '0);
    assign list_done = (r_idx == r_occ);

    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_occ     = r_occ;
        n_idx     = r_idx;
        n_strobe  = 1'b0;
        n_item    = r_item;
        n_status  = r_status;
        n_last    = r_last;
        ram_we    = 1'b0;
        ram_waddr = r_front;
        ram_raddr = r_front;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            n_strobe = 1'b1;
                            n_last   = 1'b1;
                            if (is_full) begin
                                // The word is dropped and the queue stays as it was.
                                n_item   = '0;
                                n_status = ST_FULL;
                            end else begin
                                ram_we = 1'b1;
                                if (i_cmd == CMD_PUSH_FRONT) begin
                                    // The front moves back one slot and takes the word.
                                    n_front   = ring_add(r_front, AW'(DEPTH - 1));
                                    ram_waddr = n_front;
                                end else begin
                                    // Not full, so the count fits in an address.
                                    ram_waddr = ring_add(r_front, r_occ[AW-1:0]);
                                end
                                n_occ    = r_occ + CW'(1);
                                n_item   = i_value;
                                n_status = ST_OK;
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK: begin
                            if (is_empty) begin
                                n_strobe = 1'b1;
                                n_item   = '0;
                                n_status = ST_EMPTY;
                                n_last   = 1'b1;
                            end else begin
                                // The pointers update now; the removed word arrives
                                // from memory in the next cycle.
                                if (i_cmd == CMD_POP_FRONT) begin
                                    ram_raddr = r_front;
                                    n_front   = ring_add(r_front, AW'(1));
                                end else begin
                                    ram_raddr = ring_add(r_front, AW'(r_occ - CW'(1)));
                                end
                                n_occ   = r_occ - CW'(1);
                                n_state = S_POP;
                            end
                        end
                        CMD_LIST: begin
                            if (is_empty) begin
                                n_strobe = 1'b1;
                                n_item   = '0;
                                n_status = ST_EMPTY;
                                n_last   = 1'b1;
                            end else begin
                                ram_raddr = r_front;
                                n_idx     = CW'(1);
                                n_state   = S_LIST;
                            end
                        end
                        default: begin
                            // Unknown commands are taken and ignored.
                        end
                    endcase
                end
            end
            S_POP: begin
                n_strobe = 1'b1;
                n_item   = $signed(ram_rdata);
                n_status = ST_OK;
                n_last   = 1'b1;
                n_state  = S_IDLE;
            end
            S_LIST: begin
                // Read data holds the entry at offset r_idx - 1; the next read is
                // issued in the same cycle so results stream without gaps.
                n_strobe  = 1'b1;
                n_item    = $signed(ram_rdata);
                n_status  = ST_OK;
                n_last    = list_done;
                ram_raddr = ring_add(r_front, r_idx[AW-1:0]);
                if (list_done) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_front  <= '0;
            r_occ    <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_front  <= n_front;
            r_occ    <= n_occ;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_strobe = r_strobe;
    assign o_item   = r_item;
    assign o_status = r_status;
    assign o_last   = r_last;

endmodule

### design/deq_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on deq_pkg and double_ended_queue_core.
module deq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input deq_pkg::t_cmd      i_cmd,
    input logic signed [31:0] i_value,
    input logic               o_strobe,
    input logic signed [31:0] o_item,
    input deq_pkg::t_status   o_status,
    input logic               o_last
);
    import deq_pkg::*;

    // A result that is not ok carries a zero word and ends its request.
    a_bad_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != ST_OK) |-> (o_item == '0) && o_last)
        else $error("non-ok result with nonzero item or without last");

    // A push always answers in the very next cycle with a single result.
    a_push_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd == CMD_PUSH_FRONT || i_cmd == CMD_PUSH_BACK)
        |=> o_strobe && o_last && !busy)
        else $error("push did not answer in one cycle");

    // An accepted push that succeeds echoes the pushed word.
    a_push_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd == CMD_PUSH_FRONT || i_cmd == CMD_PUSH_BACK)
        |=> (o_status == ST_FULL) || (o_item == $past(i_value)))
        else $error("push result does not echo the word");

    // Unknown commands produce no result.
    a_unknown_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd != CMD_PUSH_FRONT) && (i_cmd != CMD_PUSH_BACK)
        && (i_cmd != CMD_POP_FRONT) && (i_cmd != CMD_POP_BACK) && (i_cmd != CMD_LIST)
        |=> !o_strobe && !busy)
        else $error("unknown command produced activity");

    // A list streams without gaps until its last entry.
    a_list_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe)
        else $error("gap inside a list burst");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .i_value  (i_value),
    .o_strobe (o_strobe),
    .o_item   (o_item),
    .o_status (o_status),
    .o_last   (o_last)
);

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for double_ended_queue_core: push, pop and list requests are checked
// result by result against a shadow ring kept in the bench.
// Depends on deq_pkg and the design files under design/.
module tb;
    import deq_pkg::*;

    // Cycles with neither a request nor a result before the run is declared hung.
    localparam int STALL_LIMIT   = 2000;
    // Quiet cycles at the end; a stray result in this window is caught by the monitor.
    localparam int SETTLE_CYCLES = 40;

    // Command codes that the block must ignore without any result.
    localparam t_cmd CMD_FIRST_UNUSED = 3'd5;
    localparam t_cmd CMD_LAST_UNUSED  = 3'd7;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] word;
    } t_deq_request;

    typedef struct packed {
        logic signed [31:0] item;
        t_status            status;
        logic               last;
    } t_deq_result;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    t_cmd               i_cmd   = CMD_PUSH_FRONT;
    logic signed [31:0] i_value = '0;
    logic               busy;
    logic               o_strobe;
    logic signed [31:0] o_item;
    t_status            o_status;
    logic               o_last;

    // Requests waiting to be driven, and results that accepted requests still owe.
    t_deq_request request_backlog[$];
    t_deq_result  owed_results[$];
    t_deq_request next_request;
    t_deq_result  oldest_owed;

    // Shadow copy of the queue contents.
    logic signed [31:0] shadow_words [DEPTH];
    t_addr              shadow_head = '0;
    t_count             shadow_fill = '0;

    // Occupancy the stimulus generator expects, used only to shape request runs.
    int plan_fill    = 0;
    int planned_cmds = 0;

    int  idle_pct     = 0;
    logic req_taken   = 1'b0;
    logic drained     = 1'b0;
    int  stall_cycles = 0;
    int  mismatches   = 0;

    int push_count    = 0;
    int pop_count     = 0;
    int list_count    = 0;
    int unused_count  = 0;
    int full_count    = 0;
    int empty_count   = 0;
    int results_seen  = 0;

    double_ended_queue_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .i_value  (i_value),
        .o_strobe (o_strobe),
        .o_item   (o_item),
        .o_status (o_status),
        .o_last   (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_addr ring_step(input t_addr base, input int offset);
        return t_addr'((int'(base) + offset) % DEPTH);
    endfunction

    function automatic t_deq_result make_result(input logic signed [31:0] item,
                                                input t_status status, input logic last);
        t_deq_result r;
        r.item   = item;
        r.status = status;
        r.last   = last;
        return r;
    endfunction

    // Applies one accepted request to the shadow ring and queues the results it owes.
    task automatic predict_request(input t_cmd cmd, input logic signed [31:0] word);
        t_addr slot;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                push_count++;
                if (shadow_fill == DEPTH) begin
                    full_count++;
                    owed_results.push_back(make_result('0, ST_FULL, 1'b1));
                end else begin
                    if (cmd == CMD_PUSH_FRONT) begin
                        shadow_head = ring_step(shadow_head, DEPTH - 1);
                        slot = shadow_head;
                    end else begin
                        slot = ring_step(shadow_head, shadow_fill);
                    end
                    shadow_words[slot] = word;
                    shadow_fill++;
                    owed_results.push_back(make_result(word, ST_OK, 1'b1));
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                pop_count++;
                if (shadow_fill == 0) begin
                    empty_count++;
                    owed_results.push_back(make_result('0, ST_EMPTY, 1'b1));
                end else begin
                    if (cmd == CMD_POP_FRONT) begin
                        slot = shadow_head;
                        shadow_head = ring_step(shadow_head, 1);
                    end else begin
                        slot = ring_step(shadow_head, shadow_fill - 1);
                    end
                    shadow_fill--;
                    owed_results.push_back(make_result(shadow_words[slot], ST_OK, 1'b1));
                end
            end
            CMD_LIST: begin
                list_count++;
                if (shadow_fill == 0) begin
                    empty_count++;
                    owed_results.push_back(make_result('0, ST_EMPTY, 1'b1));
                end else begin
                    for (int k = 0; k < shadow_fill; k++) begin
                        owed_results.push_back(make_result(
                            shadow_words[ring_step(shadow_head, k)], ST_OK,
                            k == shadow_fill - 1));
                    end
                end
            end
            default: begin
                // Unused codes change nothing and owe nothing.
                unused_count++;
            end
        endcase
    endtask

    // Stimulus helpers. They only append to the backlog; the driver paces the requests.
    task automatic add_request(input t_cmd cmd, input logic signed [31:0] word);
        t_deq_request r;
        r.cmd  = cmd;
        r.word = word;
        request_backlog.push_back(r);
        if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK) begin
            if (plan_fill < DEPTH) plan_fill++;
        end else if (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK) begin
            if (plan_fill > 0) plan_fill--;
        end
        if (cmd <= CMD_LIST) planned_cmds++;
    endtask

    // Uniform words half of the time, with the signed extremes, zero and minus one mixed in.
    function automatic logic signed [31:0] random_word();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cmd random_push();
        return ($urandom_range(0, 1) != 0) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    endfunction

    function automatic t_cmd random_pop();
        return ($urandom_range(0, 1) != 0) ? CMD_POP_BACK : CMD_POP_FRONT;
    endfunction

    // Pushes until the queue is full, often a few past that, then lists it.
    task automatic add_fill_run();
        int n;
        n = $urandom_range(DEPTH - plan_fill, DEPTH - plan_fill + 3);
        repeat (n) add_request(random_push(), random_word());
        add_request(CMD_LIST, random_word());
    endtask

    // Pops until the queue is empty, sometimes past that, then lists it.
    task automatic add_drain_run();
        int n;
        n = $urandom_range(plan_fill, plan_fill + 2);
        repeat (n) add_request(random_pop(), random_word());
        add_request(CMD_LIST, random_word());
    endtask

    task automatic add_mixed_run();
        repeat ($urandom_range(4, 10)) begin
            add_request(t_cmd'($urandom_range(CMD_PUSH_FRONT, CMD_LIST)), random_word());
        end
    endtask

    task automatic add_random_requests(input int count);
        int goal;
        goal = planned_cmds + count;
        while (planned_cmds < goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2: add_fill_run();
                3, 4, 5: add_drain_run();
                6, 7, 8: add_mixed_run();
                default: add_request(t_cmd'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED)),
                                     random_word());
            endcase
        end
    endtask

    // Returns at a falling edge once every request was taken and every result came back.
    task automatic wait_until_drained();
        do @(negedge i_clk); while (!drained);
    endtask

    // Driver: presents the next request at the falling edge once the previous one was
    // taken, or idles at random when the current phase asks for gaps.
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || req_taken)) begin
            if (request_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                next_request = request_backlog.pop_front();
                i_cmd   <= next_request.cmd;
                i_value <= next_request.word;
                start   <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks each strobed result against the oldest owed one, then predicts
    // the request taken at this edge. A request never produces a result in its own cycle,
    // so the order of the two steps does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ($isunknown({busy, o_strobe})) begin
                mismatches++;
                $error("busy or o_strobe unknown: busy %b, o_strobe %b", busy, o_strobe);
            end
            if (o_strobe === 1'b1) begin
                results_seen++;
                if (owed_results.size() == 0) begin
                    mismatches++;
                    $error("result with none owed: item %0d, status %0d, last %0d",
                           o_item, o_status, o_last);
                end else begin
                    oldest_owed = owed_results.pop_front();
                    if (o_item !== oldest_owed.item) begin
                        mismatches++;
                        $error("item: expected %0d, got %0d", oldest_owed.item, o_item);
                    end
                    if (o_status !== oldest_owed.status) begin
                        mismatches++;
                        $error("status: expected %0d, got %0d", oldest_owed.status, o_status);
                    end
                    if (o_last !== oldest_owed.last) begin
                        mismatches++;
                        $error("last: expected %0d, got %0d", oldest_owed.last, o_last);
                    end
                end
            end
            if (start && !busy) predict_request(i_cmd, i_value);
            req_taken <= start && !busy;
            drained   <= request_backlog.size() == 0 && owed_results.size() == 0 && !busy;
        end
    end

    // Watchdog: any taken request or any result counts as progress.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe === 1'b1) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("tb: no progress for %0d cycles, %0d results still owed",
                         STALL_LIMIT, owed_results.size());
                $display("tb: FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one, back to back. Directed requests first: every command on an empty
        // queue, the signed extremes at both ends, the unused codes, and a drain past empty.
        idle_pct = 0;
        add_request(CMD_LIST,       32'sd5);
        add_request(CMD_POP_FRONT,  32'sd1);
        add_request(CMD_POP_BACK,   -32'sd1);
        add_request(CMD_PUSH_FRONT, 32'sh8000_0000);
        add_request(CMD_PUSH_BACK,  32'sh7fff_ffff);
        add_request(CMD_PUSH_FRONT, '0);
        add_request(CMD_PUSH_BACK,  -32'sd1);
        add_request(CMD_LIST,       '0);
        add_request(CMD_FIRST_UNUSED,            32'sh5555_aaaa);
        add_request(t_cmd'(CMD_FIRST_UNUSED + 1), 32'sh0f0f_f0f0);
        add_request(CMD_LAST_UNUSED,             -32'sd1);
        add_request(CMD_POP_BACK,   '0);
        add_request(CMD_POP_FRONT,  '0);
        add_request(CMD_LIST,       '0);
        add_request(CMD_POP_FRONT,  '0);
        add_request(CMD_POP_BACK,   '0);
        add_request(CMD_POP_BACK,   '0);
        add_request(CMD_LIST,       '0);
        // Make sure a full queue, refused pushes and a full list appear early.
        add_fill_run();
        add_random_requests(20);
        wait_until_drained();

        // Phase two: the requester idles most of the time.
        idle_pct = 79;
        add_random_requests(40);
        wait_until_drained();

        // Phase three: occasional idle cycles.
        idle_pct = 23;
        add_random_requests(40);
        wait_until_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (owed_results.size() != 0) begin
            mismatches += owed_results.size();
            $error("%0d results never arrived", owed_results.size());
        end
        $display("tb: %0d requests taken (%0d push, %0d pop, %0d list, %0d unused codes)",
                 push_count + pop_count + list_count + unused_count,
                 push_count, pop_count, list_count, unused_count);
        $display("tb: %0d results checked, %0d refused pushes, %0d empty answers, %0d errors",
                 results_seen, full_count, empty_count, mismatches);
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
